[rtl/mlfq_pkg.sv]
package mlfq_pkg;

  localparam int unsigned LEVELS         = 3;
  localparam int unsigned MAX_TASKS_DEF  = 32;
  localparam int unsigned BURST_BITS_DEF = 16;

  localparam logic [7:0] SLICE_MAX  = 8'hFF;
  localparam logic [7:0] Q0_RESET   = 8'd4;
  localparam logic [7:0] Q1_RESET   = 8'd8;

  // register indexes on the config port
  localparam logic CFG_QUANT_TOP = 1'b0;
  localparam logic CFG_QUANT_MID = 1'b1;

  // item kinds
  localparam logic ACT_TICK   = 1'b0;
  localparam logic ACT_ARRIVE = 1'b1;

  // queue levels
  localparam logic [1:0] LVL_TOP = 2'd0;
  localparam logic [1:0] LVL_MID = 2'd1;
  localparam logic [1:0] LVL_LOW = 2'd2;

  typedef struct packed {
    logic [LEVELS-1:0] nonempty;
    logic [LEVELS-1:0] full;
  } q_status_t;

  typedef struct packed {
    logic       finished;
    logic       demoted;
    logic [1:0] new_level;
  } run_flags_t;

endpackage

[rtl/mlfq_task_scheduler_unit.sv]
// channel  | handshake            | payload
// ---------+----------------------+--------------------------------------------------
// in       | in_valid / in_ready  | action, task_id, burst_length
// out      | out_valid / out_ready| accepted, busy_res, ran_task, first_run, finished,
//          |                      | demoted, new_level, remaining_after
// cfg      | cfg_we               | cfg_index, cfg_data (top and middle slice lengths)
//
// an arrival or an idle tick is answered from the idle state; a tick on a running
// task passes through S_RUN, and a tick that dispatches through S_POP and S_RUN.
// the queue slot and task memory reads are registered; one item is in work at a time.
// synchronous reset empties all queues and clears the first-run marks; no clearing pass.
// a finished item waits in the output register and the input stalls meanwhile; a new
// item is taken at the earliest at the edge where the waiting one leaves.
module mlfq_task_scheduler_unit
  import mlfq_pkg::*;
#(
  parameter int unsigned MAX_TASKS  = MAX_TASKS_DEF,
  parameter int unsigned BURST_BITS = BURST_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // config port
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  // input items
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        action,
  input  logic [4:0]  task_id,
  input  logic [15:0] burst_length,
  // result items
  output logic        out_valid,
  input  logic        out_ready,
  output logic        accepted,
  output logic        busy_res,
  output logic [4:0]  ran_task,
  output logic        first_run,
  output logic        finished,
  output logic        demoted,
  output logic [1:0]  new_level,
  output logic [15:0] remaining_after
);

  localparam int unsigned IDX_W = $clog2(MAX_TASKS);
  // remaining units never exceed the 16-bit input field
  localparam int unsigned REM_W = (BURST_BITS < 16) ? BURST_BITS : 16;

  localparam logic [1:0] S_IDLE = 2'd0;  // take an item
  localparam logic [1:0] S_POP  = 2'd1;  // slot read back, start task read
  localparam logic [1:0] S_RUN  = 2'd2;  // task data back, run one unit

  logic [1:0]       state;
  logic [7:0]       quant_top;
  logic [7:0]       quant_mid;
  logic             running_valid;
  logic [IDX_W-1:0] running_task;
  logic [7:0]       slice_used;
  logic             first_flag;
  logic [MAX_TASKS-1:0] started;

  // handshake helpers
  logic out_free;
  logic take;
  logic arrive_ok;
  logic [IDX_W-1:0] arrive_idx;

  // queue side
  logic             q_push_en;
  logic [1:0]       q_push_lvl;
  logic [IDX_W-1:0] q_push_data;
  logic             q_pop_en;
  logic [1:0]       q_pop_lvl;
  logic [IDX_W-1:0] q_pop_data;
  q_status_t        q_status;

  // task memory side
  logic             t_wr_en;
  logic [IDX_W-1:0] t_wr_addr;
  logic [REM_W-1:0] t_wr_rem;
  logic [1:0]       t_wr_lvl;
  logic             t_rd_en;
  logic [IDX_W-1:0] t_rd_addr;
  logic [REM_W-1:0] t_rd_rem;
  logic [1:0]       t_rd_lvl;

  // run unit
  logic [REM_W-1:0] rem_next;
  logic [7:0]       slice_next;
  run_flags_t       run_flags;

  assign out_free   = !out_valid || out_ready;
  // nothing is taken while reset is held
  assign in_ready   = !rst && (state == S_IDLE) && out_free;
  assign take       = in_valid && in_ready;
  assign arrive_idx = IDX_W'(task_id);
  assign arrive_ok  = (32'(task_id) < MAX_TASKS) && !q_status.full[0];

  // highest non-empty level for dispatch
  always_comb begin
    q_pop_lvl = LVL_LOW;
    if (q_status.nonempty[1]) q_pop_lvl = LVL_MID;
    if (q_status.nonempty[0]) q_pop_lvl = LVL_TOP;
  end

  // memory port steering
  always_comb begin
    q_push_en   = 1'b0;
    q_push_lvl  = LVL_TOP;
    q_push_data = arrive_idx;
    q_pop_en    = 1'b0;
    t_wr_en     = 1'b0;
    t_wr_addr   = arrive_idx;
    t_wr_rem    = REM_W'(burst_length);
    t_wr_lvl    = LVL_TOP;
    t_rd_en     = 1'b0;
    t_rd_addr   = running_task;
    case (state)
      S_IDLE: begin
        if (take && (action == ACT_ARRIVE)) begin
          q_push_en = arrive_ok;
          t_wr_en   = arrive_ok;
        end else if (take && running_valid) begin
          t_rd_en = 1'b1;
        end else if (take) begin
          q_pop_en = |q_status.nonempty;
        end
      end
      S_POP: begin
        t_rd_en   = 1'b1;
        t_rd_addr = q_pop_data;
      end
      S_RUN: begin
        if (out_free) begin
          t_wr_en     = 1'b1;
          t_wr_addr   = running_task;
          t_wr_rem    = rem_next;
          t_wr_lvl    = run_flags.new_level;
          // requeue on slice expiry; the queue drops it if full
          q_push_en   = run_flags.demoted;
          q_push_lvl  = run_flags.new_level;
          q_push_data = running_task;
        end
      end
      default: ;
    endcase
  end

  mlfq_queues #(
    .MAX_TASKS (MAX_TASKS)
  ) u_queues (
    .clk       (clk),
    .rst       (rst),
    .push_en   (q_push_en),
    .push_lvl  (q_push_lvl),
    .push_data (q_push_data),
    .pop_en    (q_pop_en),
    .pop_lvl   (q_pop_lvl),
    .pop_data  (q_pop_data),
    .status    (q_status)
  );

  mlfq_task_store #(
    .MAX_TASKS (MAX_TASKS),
    .REM_W     (REM_W)
  ) u_task_store (
    .clk     (clk),
    .wr_en   (t_wr_en),
    .wr_addr (t_wr_addr),
    .wr_rem  (t_wr_rem),
    .wr_lvl  (t_wr_lvl),
    .rd_en   (t_rd_en),
    .rd_addr (t_rd_addr),
    .rd_rem  (t_rd_rem),
    .rd_lvl  (t_rd_lvl)
  );

  mlfq_run_unit #(
    .REM_W (REM_W)
  ) u_run_unit (
    .rem        (t_rd_rem),
    .lvl        (t_rd_lvl),
    .slice      (slice_used),
    .quant_top  (quant_top),
    .quant_mid  (quant_mid),
    .rem_next   (rem_next),
    .slice_next (slice_next),
    .flags      (run_flags)
  );

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      quant_top <= Q0_RESET;
      quant_mid <= Q1_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_QUANT_TOP: quant_top <= cfg_data;
        CFG_QUANT_MID: quant_mid <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer and running-task state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      running_valid <= 1'b0;
      running_task  <= '0;
      slice_used    <= '0;
      first_flag    <= 1'b0;
      started       <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (take && (action == ACT_ARRIVE)) begin
            if (arrive_ok) begin
              started[arrive_idx] <= 1'b0;
            end
          end else if (take && running_valid) begin
            first_flag <= 1'b0;
            state      <= S_RUN;
          end else if (take && (|q_status.nonempty)) begin
            state <= S_POP;
          end
        end
        S_POP: begin
          // dispatch the popped task with a fresh slice
          running_task        <= q_pop_data;
          running_valid       <= 1'b1;
          slice_used          <= '0;
          first_flag          <= !started[q_pop_data];
          started[q_pop_data] <= 1'b1;
          state               <= S_RUN;
        end
        S_RUN: begin
          if (out_free) begin
            slice_used <= slice_next;
            if (run_flags.finished || run_flags.demoted) begin
              running_valid <= 1'b0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take && ((action == ACT_ARRIVE) || (!running_valid &&
                 !(|q_status.nonempty)))) begin
      out_valid <= 1'b1;
    end else if ((state == S_RUN) && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && (action == ACT_ARRIVE)) begin
      accepted        <= arrive_ok;
      busy_res        <= 1'b0;
      ran_task        <= '0;
      first_run       <= 1'b0;
      finished        <= 1'b0;
      demoted         <= 1'b0;
      new_level       <= '0;
      remaining_after <= '0;
    end else if (take) begin
      // idle tick result; a busy tick overwrites it in its run step
      accepted        <= 1'b0;
      busy_res        <= 1'b0;
      ran_task        <= '0;
      first_run       <= 1'b0;
      finished        <= 1'b0;
      demoted         <= 1'b0;
      new_level       <= '0;
      remaining_after <= '0;
    end else if ((state == S_RUN) && out_free) begin
      accepted        <= 1'b0;
      busy_res        <= 1'b1;
      ran_task        <= 5'(running_task);
      first_run       <= first_flag;
      finished        <= run_flags.finished;
      demoted         <= run_flags.demoted;
      new_level       <= run_flags.new_level;
      remaining_after <= 16'(rem_next);
    end
  end

endmodule

[rtl/mlfq_queues.sv]
module mlfq_queues
  import mlfq_pkg::*;
#(
  parameter int unsigned MAX_TASKS = MAX_TASKS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push_en,
  input  logic [1:0]                   push_lvl,
  input  logic [$clog2(MAX_TASKS)-1:0] push_data,
  input  logic                         pop_en,
  input  logic [1:0]                   pop_lvl,
  output logic [$clog2(MAX_TASKS)-1:0] pop_data,
  output q_status_t                    status
);

  localparam int unsigned IDX_W  = $clog2(MAX_TASKS);
  localparam int unsigned CNT_W  = $clog2(MAX_TASKS + 1);
  localparam int unsigned SLOT_W = $clog2(LEVELS * MAX_TASKS);

  logic [IDX_W-1:0] slots [LEVELS*MAX_TASKS];
  logic [IDX_W-1:0] head  [LEVELS];
  logic [IDX_W-1:0] tail  [LEVELS];
  logic [CNT_W-1:0] count [LEVELS];

  logic [SLOT_W-1:0] wr_addr;
  logic [SLOT_W-1:0] rd_addr;
  logic              do_push;

  function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] p);
    return (p == IDX_W'(MAX_TASKS - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    for (int i = 0; i < LEVELS; i++) begin
      status.nonempty[i] = (count[i] != '0);
      status.full[i]     = (count[i] == CNT_W'(MAX_TASKS));
    end
  end

  // a push into a full level is dropped
  assign do_push = push_en && !status.full[push_lvl];
  assign wr_addr = SLOT_W'(push_lvl) * SLOT_W'(MAX_TASKS) + SLOT_W'(tail[push_lvl]);
  assign rd_addr = SLOT_W'(pop_lvl) * SLOT_W'(MAX_TASKS) + SLOT_W'(head[pop_lvl]);

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_addr] <= push_data;
    end
    if (pop_en) begin
      pop_data <= slots[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LEVELS; i++) begin
        head[i]  <= '0;
        tail[i]  <= '0;
        count[i] <= '0;
      end
    end else begin
      if (do_push) begin
        tail[push_lvl]  <= wrap_inc(tail[push_lvl]);
        count[push_lvl] <= count[push_lvl] + 1'b1;
      end
      if (pop_en) begin
        head[pop_lvl]  <= wrap_inc(head[pop_lvl]);
        count[pop_lvl] <= count[pop_lvl] - 1'b1;
      end
    end
  end

endmodule

[rtl/mlfq_task_store.sv]
module mlfq_task_store
  import mlfq_pkg::*;
#(
  parameter int unsigned MAX_TASKS = MAX_TASKS_DEF,
  parameter int unsigned REM_W     = 16
) (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [$clog2(MAX_TASKS)-1:0] wr_addr,
  input  logic [REM_W-1:0]             wr_rem,
  input  logic [1:0]                   wr_lvl,
  input  logic                         rd_en,
  input  logic [$clog2(MAX_TASKS)-1:0] rd_addr,
  output logic [REM_W-1:0]             rd_rem,
  output logic [1:0]                   rd_lvl
);

  logic [REM_W-1:0] rem_mem [MAX_TASKS];
  logic [1:0]       lvl_mem [MAX_TASKS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      rem_mem[wr_addr] <= wr_rem;
      lvl_mem[wr_addr] <= wr_lvl;
    end
    if (rd_en) begin
      rd_rem <= rem_mem[rd_addr];
      rd_lvl <= lvl_mem[rd_addr];
    end
  end

endmodule

[rtl/mlfq_run_unit.sv]
module mlfq_run_unit
  import mlfq_pkg::*;
#(
  parameter int unsigned REM_W = 16
) (
  input  logic [REM_W-1:0] rem,
  input  logic [1:0]       lvl,
  input  logic [7:0]       slice,
  input  logic [7:0]       quant_top,
  input  logic [7:0]       quant_mid,
  output logic [REM_W-1:0] rem_next,
  output logic [7:0]       slice_next,
  output run_flags_t       flags
);

  logic expire;

  always_comb begin
    rem_next   = (rem == '0) ? '0 : rem - 1'b1;
    slice_next = (slice == SLICE_MAX) ? slice : slice + 1'b1;
    // level 2 never expires
    expire = ((lvl == LVL_TOP) && (slice_next >= quant_top)) ||
             ((lvl == LVL_MID) && (slice_next >= quant_mid));
    flags.finished  = (rem_next == '0);
    flags.demoted   = !flags.finished && expire;
    flags.new_level = lvl;
    if (flags.demoted && (lvl != LVL_LOW)) begin
      flags.new_level = lvl + 1'b1;
    end
  end

endmodule

[test/tb.sv]
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mlfq_pkg::*;

  localparam int CLK_PERIOD   = 8;
  localparam int RESET_CYCLES = 7;
  localparam int TARGET_ITEMS = 1050;
  localparam int STALL_LIMIT  = 3000;  // cycles without any handshake before giving up
  localparam int HOLD_CYCLES  = 240;   // long result back-pressure stretch
  localparam int SLOTS        = MAX_TASKS_DEF;

  // one result item, field order matches the output ports
  typedef struct packed {
    logic        accepted;
    logic        busy_res;
    logic [4:0]  ran_task;
    logic        first_run;
    logic        finished;
    logic        demoted;
    logic [1:0]  new_level;
    logic [15:0] remaining_after;
  } sched_report_t;

  // scheduler shadow: three ring queues, per-task bookkeeping, the cpu slot
  class mlfq_scoreboard;
    bit [7:0]  slice_q0 = Q0_RESET;
    bit [7:0]  slice_q1 = Q1_RESET;
    bit [4:0]  ring_slot [LEVELS][SLOTS];
    bit [4:0]  ring_head [LEVELS];
    bit [4:0]  ring_tail [LEVELS];
    bit [5:0]  ring_fill [LEVELS];
    bit [15:0] units_left [SLOTS];
    bit [1:0]  level_of [SLOTS];
    bit        has_run [SLOTS];
    bit        cpu_busy;
    bit [4:0]  cpu_task;
    bit [7:0]  slice_used;
    sched_report_t reports_due[$];
    int mismatches, results_seen;
    int queued, refused, busy_ticks, idle_ticks, retired, demotions, dropped;

    function bit enqueue(bit [1:0] lvl, bit [4:0] t);
      if (ring_fill[lvl] >= SLOTS) return 1'b0;
      ring_slot[lvl][ring_tail[lvl]] = t;
      ring_tail[lvl] = ring_tail[lvl] + 5'd1;
      ring_fill[lvl] = ring_fill[lvl] + 6'd1;
      return 1'b1;
    endfunction

    // works out the report for one accepted item and queues it
    function void schedule_item(bit act, bit [4:0] tid, bit [15:0] burst);
      sched_report_t r;
      int pick;
      bit [4:0] t;
      bit [1:0] lvl;
      bit [15:0] left;
      r = '0;
      if (act == ACT_ARRIVE) begin
        if (ring_fill[LVL_TOP] < SLOTS) begin
          units_left[tid] = burst;
          level_of[tid] = LVL_TOP;
          has_run[tid] = 1'b0;
          void'(enqueue(LVL_TOP, tid));
          r.accepted = 1'b1;
          queued++;
        end else begin
          refused++;
        end
        reports_due.push_back(r);
        return;
      end
      if (!cpu_busy) begin
        pick = 0;
        while (pick < LEVELS && ring_fill[pick] == 0) pick++;
        if (pick == LEVELS) begin
          idle_ticks++;
          reports_due.push_back(r);
          return;
        end
        cpu_task = ring_slot[pick][ring_head[pick]];
        ring_head[pick] = ring_head[pick] + 5'd1;
        ring_fill[pick] = ring_fill[pick] - 6'd1;
        cpu_busy = 1'b1;
        slice_used = 8'd0;
        r.first_run = !has_run[cpu_task];
        has_run[cpu_task] = 1'b1;
      end
      t = cpu_task;
      lvl = level_of[t];
      left = (units_left[t] != 16'd0) ? units_left[t] - 16'd1 : 16'd0;
      units_left[t] = left;
      if (slice_used != SLICE_MAX) slice_used = slice_used + 8'd1;
      if (left == 16'd0) begin
        r.finished = 1'b1;
        cpu_busy = 1'b0;
        retired++;
      end else if ((lvl == LVL_TOP && slice_used >= slice_q0) ||
                   (lvl == LVL_MID && slice_used >= slice_q1)) begin
        r.demoted = 1'b1;
        lvl = (lvl == LVL_TOP) ? LVL_MID : LVL_LOW;
        level_of[t] = lvl;
        if (!enqueue(lvl, t)) dropped++;
        demotions++;
        cpu_busy = 1'b0;
      end
      busy_ticks++;
      r.busy_res = 1'b1;
      r.ran_task = t;
      r.new_level = lvl;
      r.remaining_after = left;
      reports_due.push_back(r);
    endfunction

    task report_mismatch(string what, logic [15:0] got_v, logic [15:0] want_v);
      mismatches++;
      $display("[%0t] result %0d: %s got %0h want %0h", $time, results_seen, what, got_v,
               want_v);
    endtask

    task compare_field(string field, logic [15:0] got_v, logic [15:0] want_v);
      if (got_v !== want_v) report_mismatch(field, got_v, want_v);
    endtask

    task check_result(sched_report_t got);
      sched_report_t want;
      results_seen++;
      if (reports_due.size() == 0) begin
        report_mismatch("result with no item outstanding", '0, '0);
        return;
      end
      want = reports_due.pop_front();
      compare_field("accepted", 16'(got.accepted), 16'(want.accepted));
      compare_field("busy_res", 16'(got.busy_res), 16'(want.busy_res));
      compare_field("ran_task", 16'(got.ran_task), 16'(want.ran_task));
      compare_field("first_run", 16'(got.first_run), 16'(want.first_run));
      compare_field("finished", 16'(got.finished), 16'(want.finished));
      compare_field("demoted", 16'(got.demoted), 16'(want.demoted));
      compare_field("new_level", 16'(got.new_level), 16'(want.new_level));
      compare_field("remaining_after", got.remaining_after, want.remaining_after);
    endtask

    task report_leftovers();
      if (reports_due.size() != 0)
        report_mismatch("results never delivered", 16'(reports_due.size()), '0);
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic        cfg_index;
  logic [7:0]  cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic        action;
  logic [4:0]  task_id;
  logic [15:0] burst_length;
  logic        out_valid;
  logic        out_ready;
  logic        accepted;
  logic        busy_res;
  logic [4:0]  ran_task;
  logic        first_run;
  logic        finished;
  logic        demoted;
  logic [1:0]  new_level;
  logic [15:0] remaining_after;

  mlfq_scoreboard sched_sb;
  bit sender_jitter;   // random gaps between offered items
  bit sink_jitter;     // random result back-pressure
  bit hold_req;        // asks the result sink for one long stall
  int items_sent;
  int settings_used;
  int cycles_idle = 0;

  mlfq_task_scheduler_unit u_top (.*);

  initial clk = 1'b0;
  always #(CLK_PERIOD / 2) clk = ~clk;

  // mostly short gaps, now and then a long one
  function automatic int idle_len();
    return ($urandom_range(0, 11) == 0) ? $urandom_range(12, 48) : $urandom_range(1, 3);
  endfunction

  // small bursts dominate, with zero, all-ones and full-range values mixed in
  function automatic bit [15:0] pick_burst();
    int roll;
    roll = $urandom_range(0, 19);
    if (roll == 0) return 16'd0;
    if (roll == 1) return 16'hFFFF;
    if (roll <= 3) return 16'($urandom_range(0, 65535));
    if (roll <= 5) return 16'($urandom_range(17, 200));
    return 16'($urandom_range(1, 16));
  endfunction

  // result monitor, sampled at the rising edge
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sched_sb.check_result({accepted, busy_res, ran_task, first_run, finished, demoted,
                             new_level, remaining_after});
  end

  // watchdog: any handshake on either side counts as progress
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      cycles_idle <= 0;
    end else begin
      cycles_idle <= cycles_idle + 1;
      if (cycles_idle == STALL_LIMIT) begin
        $display("no handshake for %0d cycles, %0d results outstanding", STALL_LIMIT,
                 sched_sb.reports_due.size());
        $display("mlfq_task_scheduler_unit verification failed");
        $finish;
      end
    end
  end

  // result sink: random stalls, plus one long hold-off on request
  initial begin : result_sink
    int gap_left;
    gap_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (gap_left > 0) begin
        out_ready <= 1'b0;
        gap_left--;
      end else begin
        out_ready <= 1'b1;
        if (sink_jitter && $urandom_range(0, 3) == 0) gap_left = idle_len();
      end
    end
  end

  // lower valid for a pause of length n, n is never zero
  task automatic pause_input(int n);
    in_valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  // offer one item at a falling edge, hold it until taken
  task automatic send_item(bit act, bit [4:0] tid, bit [15:0] burst);
    if (sender_jitter && $urandom_range(0, 3) == 0) pause_input(idle_len());
    in_valid <= 1'b1;
    action <= act;
    task_id <= tid;
    burst_length <= burst;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sched_sb.schedule_item(act, tid, burst);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_tick();
    send_item(ACT_TICK, 5'($urandom_range(0, 31)), 16'($urandom_range(0, 65535)));
  endtask

  // stop offering and let every outstanding result come back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (sched_sb.reports_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // both quantum registers, only with the block idle
  task automatic set_quantums(bit [7:0] q0, bit [7:0] q1);
    drain_results();
    cfg_we <= 1'b1;
    cfg_index <= CFG_QUANT_TOP;
    cfg_data <= q0;
    @(negedge clk);
    cfg_index <= CFG_QUANT_MID;
    cfg_data <= q1;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    sched_sb.slice_q0 = q0;
    sched_sb.slice_q1 = q1;
    settings_used++;
  endtask

  // random arrivals and ticks; a hogging task gets cut short now and then
  task automatic run_mixed(int n);
    repeat (n) begin
      if (sched_sb.cpu_busy && sched_sb.units_left[sched_sb.cpu_task] > 64 &&
          $urandom_range(0, 5) == 0)
        send_item(ACT_ARRIVE, sched_sb.cpu_task, 16'($urandom_range(0, 4)));
      else if ($urandom_range(0, 1))
        send_item(ACT_ARRIVE, 5'($urandom_range(0, 31)), pick_burst());
      else
        send_tick();
    end
  endtask

  // a few jobs, then enough ticks to run them all out
  task automatic run_workload();
    int jobs;
    int ticks;
    bit [15:0] b;
    jobs = $urandom_range(1, 6);
    ticks = 0;
    repeat (jobs) begin
      b = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 24));
      ticks += (b == 16'd0) ? 1 : int'(b);
      send_item(ACT_ARRIVE, 5'($urandom_range(0, 31)), b);
    end
    repeat (ticks + $urandom_range(0, 3)) send_tick();
  endtask

  // overfill the top level, push it all into the middle level, then demote into
  // the full middle level; meant for a one-tick top slice on an empty scheduler
  task automatic run_storm();
    repeat ($urandom_range(33, 36))
      send_item(ACT_ARRIVE, 5'($urandom_range(0, 31)), 16'($urandom_range(2, 6)));
    repeat (SLOTS) send_tick();
    repeat (3) begin
      send_item(ACT_ARRIVE, 5'($urandom_range(0, 31)), 16'($urandom_range(2, 6)));
      send_tick();
    end
    repeat (10) send_tick();
  endtask

  // one long job that sits on the bottom level past slice saturation, then gets
  // re-armed while running
  task automatic run_long_job();
    bit [4:0] id;
    id = 5'($urandom_range(0, 31));
    send_item(ACT_ARRIVE, id, 16'd400);
    repeat (262) send_tick();
    send_item(ACT_ARRIVE, id, 16'd3);
    repeat (5) send_tick();
  endtask

  // tick until the scheduler is empty, cutting long jobs short
  task automatic settle();
    int guard;
    guard = 0;
    while ((sched_sb.cpu_busy || sched_sb.ring_fill[LVL_TOP] != 0 ||
            sched_sb.ring_fill[LVL_MID] != 0 || sched_sb.ring_fill[LVL_LOW] != 0) &&
           guard < 300) begin
      if (sched_sb.cpu_busy && sched_sb.units_left[sched_sb.cpu_task] > 40 &&
          sched_sb.ring_fill[LVL_TOP] < SLOTS)
        send_item(ACT_ARRIVE, sched_sb.cpu_task, 16'($urandom_range(0, 2)));
      else
        send_tick();
      guard++;
    end
  endtask

  initial begin : stimulus
    bit [7:0] q0;
    bit [7:0] q1;
    sched_sb = new();
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = CFG_QUANT_TOP;
    cfg_data = '0;
    in_valid = 1'b0;
    action = ACT_TICK;
    task_id = '0;
    burst_length = '0;
    sender_jitter = 1'b0;
    sink_jitter = 1'b1;
    hold_req = 1'b0;
    items_sent = 0;
    settings_used = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed part at the reset quantums (4 and 8)
    send_item(ACT_TICK, '0, '0);                 // idle tick on an empty scheduler
    send_item(ACT_ARRIVE, 5'd0, 16'd0);          // zero burst
    send_item(ACT_TICK, '0, '0);                 // retires on its first tick
    send_item(ACT_ARRIVE, 5'd31, 16'hFFFF);      // top id, longest burst
    send_item(ACT_ARRIVE, 5'd10, 16'd1);
    repeat (4) send_item(ACT_TICK, 5'd31, 16'hFFFF);  // slice runs out, drops a level
    send_item(ACT_TICK, '0, '0);                 // short job retires
    send_item(ACT_TICK, '0, '0);                 // long job resumes from the middle level
    send_item(ACT_ARRIVE, 5'd31, 16'd3);         // re-arrival of the running task
    repeat (3) send_item(ACT_TICK, '0, '0);      // runs out the new burst
    send_item(ACT_TICK, '0, '0);                 // second queue entry, counts as a first run
    send_item(ACT_TICK, '0, '0);                 // empty again

    // one-tick slices: bottom-level saturation, overflow and demotion into a full level
    set_quantums(8'd1, 8'd1);
    run_long_job();
    settle();
    run_storm();
    settle();

    // widest slices, no idling on either side
    set_quantums(8'd255, 8'd255);
    sender_jitter = 1'b0;
    sink_jitter = 1'b0;
    run_mixed(60);
    run_workload();

    // zero quantums: every top and middle level slice expires after one tick
    set_quantums(8'd0, 8'd0);
    sender_jitter = 1'b1;
    sink_jitter = 1'b1;
    run_workload();
    run_mixed(50);

    // long result hold-off while items keep coming, then a full pause
    set_quantums(8'd1, 8'd255);
    hold_req = 1'b1;
    run_mixed(40);
    drain_results();
    run_mixed(40);
    run_workload();

    // random settings until the item budget is spent
    while (items_sent < TARGET_ITEMS) begin
      q0 = ($urandom_range(0, 5) == 0) ? 8'($urandom_range(13, 255)) :
                                         8'($urandom_range(1, 12));
      q1 = ($urandom_range(0, 5) == 0) ? 8'($urandom_range(13, 255)) :
                                         8'($urandom_range(1, 12));
      set_quantums(q0, q1);
      sender_jitter = $urandom_range(0, 3) != 0;
      sink_jitter = $urandom_range(0, 3) != 0;
      repeat ($urandom_range(2, 4)) begin
        if (items_sent >= TARGET_ITEMS) break;
        if ($urandom_range(0, 1)) run_workload();
        else run_mixed($urandom_range(20, 60));
      end
    end

    drain_results();
    repeat (8) @(negedge clk);
    sched_sb.report_leftovers();

    $display("covered %0d items over %0d quantum settings: %0d arrivals queued, %0d refused",
             items_sent, settings_used, sched_sb.queued, sched_sb.refused);
    $display("%0d busy and %0d idle ticks, %0d retirements, %0d demotions (%0d dropped)",
             sched_sb.busy_ticks, sched_sb.idle_ticks, sched_sb.retired, sched_sb.demotions,
             sched_sb.dropped);
    if (sched_sb.mismatches == 0) begin
      $display("mlfq_task_scheduler_unit verification clean");
    end else begin
      $display("mlfq_task_scheduler_unit verification failed");
    end
    $finish;
  end

endmodule
